FILE: rtl/xtea_pkg.sv
// Shared constants, types and round functions for the XTEA cipher block.
package xtea_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  rounds_t;
	typedef logic [3:0][31:0] key_set_t;

	// Round sum increment.
	localparam word_t DELTA = 32'h9E3779B9;

	// Key and round count values after reset.
	localparam word_t   KEY0_RESET = 32'hF0E1D2C3;
	localparam word_t   KEY1_RESET = 32'hB4A59687;
	localparam word_t   KEY2_RESET = 32'h78695A4B;
	localparam word_t   KEY3_RESET = 32'h3C2D1E0F;
	localparam rounds_t ROUNDS_RESET = 8'd32;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ROUNDS = 3'd4;

	// Opcodes.
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Default depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// One classified job waiting for the round engine.
	typedef struct packed {
		logic    dec;
		word_t   a;
		word_t   b;
		word_t   sum;
		rounds_t rounds;
	} job_t;

	// Feistel mixing term without the key part.
	function automatic word_t mix(input word_t x);
		mix = ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

FILE: rtl/xtea_if.sv
// Valid/ready channel interfaces for cipher requests and results.
interface xtea_in_if;
	import xtea_pkg::*;
	logic  valid;
	logic  ready;
	logic  opcode;
	word_t block_first;
	word_t block_second;

	modport source (output valid, output opcode, output block_first, output block_second,
		input ready);
	modport sink (input valid, input opcode, input block_first, input block_second,
		output ready);
endinterface

interface xtea_out_if;
	import xtea_pkg::*;
	logic  valid;
	logic  ready;
	word_t result_first;
	word_t result_second;

	modport source (output valid, output result_first, output result_second, input ready);
	modport sink (input valid, input result_first, input result_second, output ready);
endinterface

FILE: rtl/xtea_front.sv
// Front stage: accepts requests and prepares the start sum for each job.
module xtea_front
	import xtea_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	xtea_in_if.sink blk_in,
	input  rounds_t round_count,
	output logic    push,
	output job_t    push_job,
	input  logic    full
);

	logic valid_s1;
	job_t job_s1;
	logic take;

	// The stage frees up whenever its job moves into the queue.
	assign blk_in.ready = !valid_s1 || !full;
	assign take         = blk_in.valid && blk_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	// Decryption starts at delta times the round count, encryption at zero.
	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.dec    <= (blk_in.opcode == OP_DECRYPT);
			job_s1.a      <= blk_in.block_first;
			job_s1.b      <= blk_in.block_second;
			job_s1.rounds <= round_count;
			job_s1.sum    <= (blk_in.opcode == OP_DECRYPT)
				? word_t'(DELTA * word_t'(round_count)) : '0;
		end
	end

	assign push     = valid_s1;
	assign push_job = job_s1;

endmodule

FILE: rtl/xtea_queue.sv
// Short job queue that decouples the front stage from the round engine.
module xtea_queue
	import xtea_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/xtea_core.sv
// Round engine: runs one full XTEA round per cycle and holds the result.
module xtea_core
	import xtea_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  key_set_t     keys,
	input  logic         empty,
	input  job_t         pop_job,
	output logic         pop,
	xtea_out_if.source   blk_out
);

	logic    busy_q;
	logic    dec_q;
	word_t   a_q;
	word_t   b_q;
	word_t   sum_q;
	rounds_t cnt_q;
	logic    out_valid_q;
	word_t   result_first_q;
	word_t   result_second_q;

	logic  out_free;
	logic  finish;
	logic  can_load;
	word_t sum_next;
	word_t a_next;
	word_t b_next;

	assign out_free = !out_valid_q || blk_out.ready;
	assign finish   = busy_q && (cnt_q == '0) && out_free;
	assign can_load = !busy_q || finish;
	assign pop      = can_load && !empty;

	// One round in either direction.
	always_comb begin
		if (!dec_q) begin
			a_next   = a_q + (mix(b_q) ^ (sum_q + keys[sum_q[1:0]]));
			sum_next = sum_q + DELTA;
			b_next   = b_q + (mix(a_next) ^ (sum_next + keys[sum_next[12:11]]));
		end else begin
			b_next   = b_q - (mix(a_q) ^ (sum_q + keys[sum_q[12:11]]));
			sum_next = sum_q - DELTA;
			a_next   = a_q - (mix(b_next) ^ (sum_next + keys[sum_next[1:0]]));
		end
	end

	// Engine control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= pop_job.rounds;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Working block and sum.
	always_ff @(posedge clk) begin
		if (pop) begin
			dec_q <= pop_job.dec;
			a_q   <= pop_job.a;
			b_q   <= pop_job.b;
			sum_q <= pop_job.sum;
		end else if (busy_q && cnt_q != '0) begin
			a_q   <= a_next;
			b_q   <= b_next;
			sum_q <= sum_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (blk_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_first_q  <= a_q;
			result_second_q <= b_q;
		end
	end

	assign blk_out.valid         = out_valid_q;
	assign blk_out.result_first  = result_first_q;
	assign blk_out.result_second = result_second_q;

`ifndef NO_ASSERTIONS
	// A running job counts down by one each cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != '0 && !pop |=> busy_q && cnt_q == rounds_t'($past(cnt_q) - 1'b1))
		else $error("round counter did not step");

	// A finished job always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("finished job lost");

	// A new job is only taken when the engine is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q || finish)
		else $error("job loaded over a running job");
`endif

endmodule

FILE: rtl/xtea_block_cipher_top.sv
// Top level of the XTEA block cipher with its configuration registers.
// Requests pass through the front stage register and the job queue into the round engine,
// which runs one full round per cycle, then into the output register; the engine loads
// the next job in the same cycle as its finished result enters the output register.
// Reset: keys return to their fixed values, round count to 32, the job queue empty.
module xtea_block_cipher_top
	import xtea_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  word_t                  cfg_data,
	xtea_in_if.sink                blk_in,
	xtea_out_if.source             blk_out
);

	key_set_t keys_q;
	rounds_t  round_count_q;
	logic     push;
	job_t     push_job;
	logic     full;
	logic     pop;
	job_t     pop_job;
	logic     empty;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q[0]     <= KEY0_RESET;
			keys_q[1]     <= KEY1_RESET;
			keys_q[2]     <= KEY2_RESET;
			keys_q[3]     <= KEY3_RESET;
			round_count_q <= ROUNDS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY0:   keys_q[0] <= cfg_data;
				REG_KEY1:   keys_q[1] <= cfg_data;
				REG_KEY2:   keys_q[2] <= cfg_data;
				REG_KEY3:   keys_q[3] <= cfg_data;
				REG_ROUNDS: round_count_q <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	xtea_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk_in      (blk_in),
		.round_count (round_count_q),
		.push        (push),
		.push_job    (push_job),
		.full        (full)
	);

	xtea_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	xtea_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys_q),
		.empty   (empty),
		.pop_job (pop_job),
		.pop     (pop),
		.blk_out (blk_out)
	);

endmodule

FILE: dv/tb_xtea_block_cipher_top.sv
// Self-checking testbench for the XTEA block cipher top level with randomized traffic and keys.
`timescale 1ns / 1ps

module tb_xtea_block_cipher_top;
	import xtea_pkg::*;

	// Register indexes past the last implemented register; writes to them must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] KEY_INDEX [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

	localparam int DIR_ROW_COUNT = 24;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		word_t first;
		word_t second;
	} block_t;

	// One row of the directed stimulus: either a register write or a block request.
	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		word_t                  data;
		logic                   op;
		word_t                  a;
		word_t                  b;
		bit                     typed;
		block_t                 want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	word_t cfg_data;

	xtea_in_if  blk_in_if ();
	xtea_out_if blk_out_if ();

	// Shadow copy of the key and round count that the cipher predictor runs on.
	word_t   key_words [4];
	rounds_t round_limit;

	block_t expected_blocks [$];
	int     mismatch_count;
	dir_row_t dir_rows [DIR_ROW_COUNT];

	xtea_block_cipher_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk_in    (blk_in_if),
		.blk_out   (blk_out_if)
	);

	// Free-running clock with an 8 ns period.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard limit on the run in case the block stops answering.
	initial begin
		#16_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic word_t feistel_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// Predicts the transformed block from the current key and round count.
	function automatic block_t cipher_block(input logic op, input word_t a, input word_t b);
		word_t  x;
		word_t  y;
		word_t  s;
		block_t r;
		x = a;
		y = b;
		if (op == OP_ENCRYPT) begin
			s = '0;
			for (int i = 0; i < int'(round_limit); i++) begin
				x = x + (feistel_mix(y) ^ (s + key_words[s[1:0]]));
				s = s + DELTA;
				y = y + (feistel_mix(x) ^ (s + key_words[s[12:11]]));
			end
		end else begin
			s = DELTA * {24'd0, round_limit};
			for (int i = 0; i < int'(round_limit); i++) begin
				y = y - (feistel_mix(x) ^ (s + key_words[s[12:11]]));
				s = s - DELTA;
				x = x - (feistel_mix(y) ^ (s + key_words[s[1:0]]));
			end
		end
		r.first  = x;
		r.second = y;
		return r;
	endfunction

	// Random word biased toward all zeros, all ones and single set bits.
	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	function automatic dir_row_t item_row(input logic op, input word_t a, input word_t b);
		dir_row_t r;
		r = '{default: '0};
		r.op = op;
		r.a  = a;
		r.b  = b;
		return r;
	endfunction

	function automatic dir_row_t pass_row(input logic op, input word_t a, input word_t b,
		input word_t want_first, input word_t want_second);
		dir_row_t r;
		r = item_row(op, a, b);
		r.typed       = 1'b1;
		r.want.first  = want_first;
		r.want.second = want_second;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx, input word_t data);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Register write; the shadow copy follows with only the implemented bits kept.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input word_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_words[idx[1:0]] = data;
			REG_ROUNDS: round_limit = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Presents one block and holds it until the request transaction completes.
	task automatic send_block(input logic op, input word_t a, input word_t b,
		input bit typed, input block_t typed_want);
		block_t want;
		want = typed ? typed_want : cipher_block(op, a, b);
		blk_in_if.valid        <= 1'b1;
		blk_in_if.opcode       <= op;
		blk_in_if.block_first  <= a;
		blk_in_if.block_second <= b;
		do @(posedge clk); while (blk_in_if.ready !== 1'b1);
		expected_blocks.push_back(want);
		@(negedge clk);
	endtask

	// Stops sending and waits until every outstanding block has come back.
	task automatic drain();
		blk_in_if.valid <= 1'b0;
		while (expected_blocks.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// New key and round count for one random phase; the first phases hit the extremes.
	task automatic configure_phase(input int phase);
		rounds_t r;
		word_t   high_bits;
		for (int k = 0; k < 4; k++) begin
			if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(KEY_INDEX[k], pick_word());
		end
		case (phase)
			0: r = 8'd0;
			1: r = 8'd1;
			2: r = 8'd255;
			3: r = ROUNDS_RESET;
			default: begin
				case ($urandom_range(0, 3))
					0: r = ROUNDS_RESET;
					1: r = rounds_t'($urandom_range(1, 16));
					2: r = rounds_t'($urandom_range(17, 64));
					default: r = rounds_t'($urandom_range(0, 255));
				endcase
			end
		endcase
		high_bits = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_FF00) : '0;
		write_reg(REG_ROUNDS, high_bits | word_t'(r));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom());
		end
	endtask

	// Receiver stalls in modes of random length: always ready, mostly ready, mostly
	// stalled, and long stalls broken by short ready windows.
	initial begin : result_receiver
		int mode;
		int mode_left;
		int stall_left;
		mode       = 0;
		mode_left  = 0;
		stall_left = 0;
		blk_out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			case (mode)
				0: blk_out_if.ready <= 1'b1;
				1: blk_out_if.ready <= ($urandom_range(0, 9) < 7);
				2: blk_out_if.ready <= ($urandom_range(0, 9) < 3);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						blk_out_if.ready <= 1'b0;
					end else begin
						blk_out_if.ready <= 1'b1;
						if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(0, 60);
					end
				end
			endcase
		end
	end

	// Compares each result transaction with the oldest outstanding block.
	always @(posedge clk) begin : result_check
		block_t want;
		if (arst_n === 1'b1 && blk_out_if.valid === 1'b1 && blk_out_if.ready === 1'b1) begin
			if (expected_blocks.size() == 0) begin
				flag_mismatch("result transaction with no block outstanding");
			end else begin
				want = expected_blocks.pop_front();
				if (blk_out_if.result_first !== want.first) begin
					flag_mismatch($sformatf("result_first %h, predicted %h",
						blk_out_if.result_first, want.first));
				end
				if (blk_out_if.result_second !== want.second) begin
					flag_mismatch($sformatf("result_second %h, predicted %h",
						blk_out_if.result_second, want.second));
				end
			end
		end
	end

	// Reset, directed table, then random phases with bursty traffic.
	initial begin : stimulus
		int     sent;
		int     phase;
		int     phase_items;
		int     burst;
		int     gap_max;
		int     gap;
		bit     have_cipher;
		block_t last_cipher;
		logic   op;
		word_t  a;
		word_t  b;

		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_KEY0;
		cfg_data     = '0;
		blk_in_if.valid        = 1'b0;
		blk_in_if.opcode       = OP_ENCRYPT;
		blk_in_if.block_first  = '0;
		blk_in_if.block_second = '0;
		mismatch_count = 0;
		key_words[0] = KEY0_RESET;
		key_words[1] = KEY1_RESET;
		key_words[2] = KEY2_RESET;
		key_words[3] = KEY3_RESET;
		round_limit  = ROUNDS_RESET;

		dir_rows = '{
			item_row(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000),
			item_row(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000),
			item_row(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			item_row(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			item_row(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555),
			item_row(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA),
			// With zero rounds both directions pass the block through.
			cfg_row(REG_ROUNDS, 32'h0000_0000),
			pass_row(OP_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0),
			pass_row(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000),
			// Writes past the last register must leave the round count at zero.
			cfg_row(REG_SPARE_FIRST, 32'h0000_0020),
			pass_row(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF),
			cfg_row(REG_SPARE_LAST, 32'hFFFF_FFFF),
			pass_row(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001),
			// Upper bits of a round count write are dropped, leaving one round.
			cfg_row(REG_ROUNDS, 32'hFFFF_FF01),
			item_row(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000),
			item_row(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000),
			cfg_row(REG_KEY0, 32'h0000_0000),
			cfg_row(REG_KEY1, 32'hFFFF_FFFF),
			cfg_row(REG_KEY2, 32'h0000_0000),
			cfg_row(REG_KEY3, 32'hFFFF_FFFF),
			item_row(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF),
			cfg_row(REG_ROUNDS, 32'h0000_00FF),
			item_row(OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000),
			item_row(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed table: register rows wait for the block to go idle first.
		for (int i = 0; i < DIR_ROW_COUNT; i++) begin
			if (dir_rows[i].is_cfg) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_block(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases; each starts from an idle block with a fresh configuration.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			configure_phase(phase);
			phase_items = (round_limit > 8'd64) ? 40 : 120;
			gap_max     = (phase % 3 == 2) ? 0 : 20;
			have_cipher = 1'b0;
			while (phase_items > 0) begin
				burst = $urandom_range(1, 16);
				while (burst > 0 && phase_items > 0) begin
					// Mostly fresh blocks, sometimes the decryption of an earlier ciphertext.
					if (have_cipher && $urandom_range(0, 4) == 0) begin
						op = OP_DECRYPT;
						a  = last_cipher.first;
						b  = last_cipher.second;
					end else begin
						op = logic'($urandom_range(0, 1));
						a  = pick_word();
						b  = pick_word();
					end
					if (op == OP_ENCRYPT) begin
						last_cipher = cipher_block(op, a, b);
						have_cipher = 1'b1;
					end
					send_block(op, a, b, 1'b0, '0);
					burst--;
					phase_items--;
					sent++;
				end
				gap = $urandom_range(0, gap_max);
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end else if (gap > 0) begin
					blk_in_if.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_blocks.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: xtea_block_cipher_top.f
rtl/xtea_pkg.sv
rtl/xtea_if.sv
rtl/xtea_front.sv
rtl/xtea_queue.sv
rtl/xtea_core.sv
rtl/xtea_block_cipher_top.sv
dv/tb_xtea_block_cipher_top.sv
